// ===== sv/reop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reop_pkg
// Shared types, constants and tables of the rotated ellipse orbit point block.
// ----------------------------------------------------------------------------
package reop_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 18;

   localparam int LEN_W     = 31;
   localparam int TILT_W    = 16;
   localparam int SQ_W      = 2 * LEN_W;
   localparam int SQRT_CELLS = LEN_W;
   localparam int DIV_CELLS  = LEN_W + ANGLE_BITS;
   localparam int CS_W      = 34;
   localparam int TAB_IDX_W = 5;
   localparam int CIDX_W    = TAB_IDX_W;
   localparam int N_ANG     = 4;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1 << FRAC_BITS);
   localparam logic signed [CS_W-1:0] CORDIC_K = 34'sd652032874;

   // angle slots of the cordic row
   localparam int ANG_PHASE = 0;
   localparam int ANG_TX    = 1;
   localparam int ANG_TY    = 2;
   localparam int ANG_TZ    = 3;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SEMI_MAJOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEMI_MINOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORBIT_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TILT_X       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TILT_Y       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TILT_Z       = 3'd5;

   localparam int FAULT_W = 2;
   localparam logic [FAULT_W-1:0] FAULT_NONE       = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_PERIOD     = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_MINOR_AXIS = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0]                 a;
      logic [LEN_W-1:0]                 b;
      logic [LEN_W-1:0]                 p;
      logic [LEN_W-1:0]                 num;
      logic [TILT_W-1:0]                tx;
      logic [TILT_W-1:0]                ty;
      logic [TILT_W-1:0]                tz;
      logic [FAULT_W-1:0]               fault;
      logic [SQ_W-1:0]                  rad;
      logic [LEN_W+2:0]                 srem;
      logic [LEN_W-1:0]                 root;
      logic [LEN_W:0]                   drem;
      logic [ANGLE_BITS-1:0]            dq;
      logic [N_ANG-1:0][1:0]            quad;
      logic [N_ANG-1:0][CS_W-1:0]       cx;
      logic [N_ANG-1:0][CS_W-1:0]       cy;
      logic [N_ANG-1:0][CS_W-1:0]       cz;
   } item_type;

   typedef struct packed {
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic signed [31:0]  pos_z;
      logic [FAULT_W-1:0]  fault;
   } result_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [CS_W-1:0] atan_turn(input logic [TAB_IDX_W-1:0] idx);
      logic signed [CS_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;
         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;
         5'd27: v = 34'sd5;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/reop_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reop channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface reop_req_if;
   logic                       valid;
   logic                       ready;
   logic [reop_pkg::LEN_W-1:0] elapsed_time;
   modport source (output valid, output elapsed_time, input ready);
   modport sink   (input valid, input elapsed_time, output ready);
endinterface

interface reop_rsp_if;
   logic                         valid;
   logic                         ready;
   logic signed [31:0]           pos_x;
   logic signed [31:0]           pos_y;
   logic signed [31:0]           pos_z;
   logic [reop_pkg::FAULT_W-1:0] fault;
   modport source (output valid, output pos_x, output pos_y, output pos_z, output fault,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, input fault,
                   output ready);
endinterface

interface reop_csr_if;
   logic                           valid;
   logic                           ready;
   logic [reop_pkg::CSR_IDX_W-1:0] index;
   logic [reop_pkg::LEN_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/reop_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reop_sqrt_cell
// One root bit of the focal distance square root per cell.
// ----------------------------------------------------------------------------
module reop_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  reop_pkg::item_type in_item,
   output logic               out_valid,
   output reop_pkg::item_type out_item
);
   localparam int RW = reop_pkg::LEN_W + 3;

   logic               valid_ff;
   reop_pkg::item_type item_ff, item_in;
   logic [RW-1:0]      rem_sh;
   logic [RW-1:0]      trial;

   always_comb begin
      item_in = in_item;
      rem_sh  = {in_item.srem[RW-3:0], in_item.rad[reop_pkg::SQ_W-1 -: 2]};
      trial   = {1'b0, in_item.root, 2'b01};
      item_in.rad = {in_item.rad[reop_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         item_in.srem = rem_sh - trial;
         item_in.root = {in_item.root[reop_pkg::LEN_W-2:0], 1'b1};
      end else begin
         item_in.srem = rem_sh;
         item_in.root = {in_item.root[reop_pkg::LEN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

// ===== sv/reop_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reop_div_cell
// One quotient bit of the phase division per cell.
// ----------------------------------------------------------------------------
module reop_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  reop_pkg::item_type in_item,
   output logic               out_valid,
   output reop_pkg::item_type out_item
);
   localparam int LW = reop_pkg::LEN_W;

   logic               valid_ff;
   reop_pkg::item_type item_ff, item_in;
   logic [LW:0]        rem_sh;
   logic               qbit;

   always_comb begin
      item_in = in_item;
      rem_sh  = {in_item.drem[LW-1:0], in_item.num[LW-1]};
      qbit    = (rem_sh >= {1'b0, in_item.p});
      item_in.num  = {in_item.num[LW-2:0], 1'b0};
      item_in.drem = qbit ? rem_sh - {1'b0, in_item.p} : rem_sh;
      item_in.dq   = {in_item.dq[reop_pkg::ANGLE_BITS-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

// ===== sv/reop_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reop_cordic_cell
// One rotation step for the four angles of an item.
// ----------------------------------------------------------------------------
module reop_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [reop_pkg::CIDX_W-1:0]   stage_idx,
   input  logic                          in_valid,
   input  reop_pkg::item_type            in_item,
   output logic                          out_valid,
   output reop_pkg::item_type            out_item
);
   localparam int W = reop_pkg::CS_W;

   logic                  valid_ff;
   reop_pkg::item_type    item_ff, item_in;
   logic signed [W-1:0]   atn;
   logic signed [W-1:0]   xv [reop_pkg::N_ANG];
   logic signed [W-1:0]   yv [reop_pkg::N_ANG];
   logic signed [W-1:0]   zv [reop_pkg::N_ANG];
   logic signed [W-1:0]   xs [reop_pkg::N_ANG];
   logic signed [W-1:0]   ys [reop_pkg::N_ANG];

   assign atn = reop_pkg::atan_turn(stage_idx);

   always_comb begin
      item_in = in_item;
      for (int k = 0; k < reop_pkg::N_ANG; k++) begin
         xv[k] = $signed(in_item.cx[k]);
         yv[k] = $signed(in_item.cy[k]);
         zv[k] = $signed(in_item.cz[k]);
         xs[k] = xv[k] >>> stage_idx;
         ys[k] = yv[k] >>> stage_idx;
         if (!zv[k][W-1]) begin
            item_in.cx[k] = xv[k] - ys[k];
            item_in.cy[k] = yv[k] + xs[k];
            item_in.cz[k] = zv[k] - atn;
         end else begin
            item_in.cx[k] = xv[k] + ys[k];
            item_in.cy[k] = yv[k] - xs[k];
            item_in.cz[k] = zv[k] + atn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

// ===== sv/reop_rot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reop_rot
// Ellipse point and the three axis rotations, eight register stages.
// ----------------------------------------------------------------------------
module reop_rot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  reop_pkg::item_type   in_item,
   output logic                 out_valid,
   output reop_pkg::result_type out_result
);
   localparam int TW = reop_pkg::CS_W;
   localparam int CW = 36;
   localparam int PW = CW + TW;
   localparam int RW = PW - 30;
   localparam int NSTG = 8;

   typedef struct packed {
      logic signed [TW-1:0] cx;
      logic signed [TW-1:0] sx;
      logic signed [TW-1:0] cy;
      logic signed [TW-1:0] sy;
      logic signed [TW-1:0] cz;
      logic signed [TW-1:0] sz;
      logic [reop_pkg::FAULT_W-1:0] fault;
   } trig_type;

   function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] s;
      s = v + PW'(64'sd536870912);
      return s[PW-1:30];
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [RW:0] v);
      logic signed [31:0] r;
      if (v > (RW+1)'(64'sd2147483647)) begin
         r = 32'sh7fffffff;
      end else if (v < -(RW+1)'(64'sd2147483648)) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [TW-1:0] cos_m [reop_pkg::N_ANG];
   logic signed [TW-1:0] sin_m [reop_pkg::N_ANG];

   always_comb begin
      for (int k = 0; k < reop_pkg::N_ANG; k++) begin
         case (in_item.quad[k])
            2'd0: begin
               cos_m[k] = $signed(in_item.cx[k]);
               sin_m[k] = $signed(in_item.cy[k]);
            end
            2'd1: begin
               cos_m[k] = -$signed(in_item.cy[k]);
               sin_m[k] = $signed(in_item.cx[k]);
            end
            2'd2: begin
               cos_m[k] = -$signed(in_item.cx[k]);
               sin_m[k] = -$signed(in_item.cy[k]);
            end
            default: begin
               cos_m[k] = $signed(in_item.cy[k]);
               sin_m[k] = -$signed(in_item.cx[k]);
            end
         endcase
      end
   end

   logic [NSTG-1:0]      vld_ff;
   trig_type             tr_ff [NSTG-1];
   trig_type             tr_in;
   logic [reop_pkg::LEN_W-1:0] c0_ff;
   logic signed [TW-1:0] cp0_ff, sp0_ff;
   logic [reop_pkg::LEN_W-1:0] a0_ff, b0_ff;
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic [reop_pkg::LEN_W-1:0] c1_ff;
   logic signed [CW-1:0] x_ff, z_ff, x3s_ff, x4_ff;
   logic signed [PW-1:0] m_zs_ff, m_zc_ff;
   logic signed [CW-1:0] y1_ff, z1_ff, z1b_ff, z1c_ff;
   logic signed [PW-1:0] m_xc_ff, m_ys_ff, m_xs_ff, m_yc_ff;
   logic signed [CW-1:0] x2_ff, y2_ff, y2b_ff;
   logic signed [PW-1:0] m_x2c_ff, m_z1s_ff, m_z1c_ff, m_x2s_ff;
   logic [reop_pkg::FAULT_W-1:0] fault_ff;

   logic signed [RW-1:0] r_pa, r_pb, r_zs, r_zc, r_xc, r_ys, r_xs, r_yc;
   logic signed [RW-1:0] r_x2c, r_z1s, r_z1c, r_x2s;
   logic signed [RW:0]   x3_sum, z3_sum;
   logic signed [RW:0]   x2_sum, y2_sum;

   assign tr_in = '{cx: cos_m[reop_pkg::ANG_TX], sx: sin_m[reop_pkg::ANG_TX],
                    cy: cos_m[reop_pkg::ANG_TY], sy: sin_m[reop_pkg::ANG_TY],
                    cz: cos_m[reop_pkg::ANG_TZ], sz: sin_m[reop_pkg::ANG_TZ],
                    fault: in_item.fault};

   assign r_pa  = rnd(pa_ff);
   assign r_pb  = rnd(pb_ff);
   assign r_zs  = rnd(m_zs_ff);
   assign r_zc  = rnd(m_zc_ff);
   assign r_xc  = rnd(m_xc_ff);
   assign r_ys  = rnd(m_ys_ff);
   assign r_xs  = rnd(m_xs_ff);
   assign r_yc  = rnd(m_yc_ff);
   assign r_x2c = rnd(m_x2c_ff);
   assign r_z1s = rnd(m_z1s_ff);
   assign r_z1c = rnd(m_z1c_ff);
   assign r_x2s = rnd(m_x2s_ff);
   assign x2_sum = {r_xc[RW-1], r_xc} - {r_ys[RW-1], r_ys};
   assign y2_sum = {r_xs[RW-1], r_xs} + {r_yc[RW-1], r_yc};
   assign x3_sum = {r_x2c[RW-1], r_x2c} + {r_z1s[RW-1], r_z1s};
   assign z3_sum = {r_z1c[RW-1], r_z1c} - {r_x2s[RW-1], r_x2s};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 0: trig select
         tr_ff[0] <= tr_in;
         cp0_ff   <= cos_m[reop_pkg::ANG_PHASE];
         sp0_ff   <= sin_m[reop_pkg::ANG_PHASE];
         a0_ff    <= in_item.a;
         b0_ff    <= in_item.b;
         c0_ff    <= in_item.root;
         // stage 1: a*cos, b*sin
         tr_ff[1] <= tr_ff[0];
         pa_ff    <= $signed({5'b0, a0_ff}) * cp0_ff;
         pb_ff    <= $signed({5'b0, b0_ff}) * sp0_ff;
         c1_ff    <= c0_ff;
         // stage 2: ellipse point
         tr_ff[2] <= tr_ff[1];
         x_ff     <= r_pa[CW-1:0] + $signed({5'b0, c1_ff});
         z_ff     <= r_pb[CW-1:0];
         // stage 3: about x products
         tr_ff[3] <= tr_ff[2];
         m_zs_ff  <= z_ff * tr_ff[2].sx;
         m_zc_ff  <= z_ff * tr_ff[2].cx;
         x3s_ff   <= x_ff;
         // stage 4: about x sums
         tr_ff[4] <= tr_ff[3];
         y1_ff    <= -r_zs[CW-1:0];
         z1_ff    <= r_zc[CW-1:0];
         x4_ff    <= x3s_ff;
         // stage 5: about z products
         tr_ff[5] <= tr_ff[4];
         m_xc_ff  <= x4_ff * tr_ff[4].cz;
         m_ys_ff  <= y1_ff * tr_ff[4].sz;
         m_xs_ff  <= x4_ff * tr_ff[4].sz;
         m_yc_ff  <= y1_ff * tr_ff[4].cz;
         z1b_ff   <= z1_ff;
         // stage 6: about z sums
         tr_ff[6] <= tr_ff[5];
         x2_ff    <= x2_sum[CW-1:0];
         y2_ff    <= y2_sum[CW-1:0];
         z1c_ff   <= z1b_ff;
         // stage 7: about y products
         m_x2c_ff <= x2_ff * tr_ff[6].cy;
         m_z1s_ff <= z1c_ff * tr_ff[6].sy;
         m_z1c_ff <= z1c_ff * tr_ff[6].cy;
         m_x2s_ff <= x2_ff * tr_ff[6].sy;
         y2b_ff   <= y2_ff;
         fault_ff <= tr_ff[6].fault;
      end
   end

   always_comb begin
      out_result.fault = fault_ff;
      if (fault_ff != reop_pkg::FAULT_NONE) begin
         out_result.pos_x = '0;
         out_result.pos_y = '0;
         out_result.pos_z = '0;
      end else begin
         out_result.pos_x = sat(x3_sum);
         out_result.pos_y = sat({{(RW+1-CW){y2b_ff[CW-1]}}, y2b_ff});
         out_result.pos_z = sat(z3_sum);
      end
   end

   assign out_valid = vld_ff[NSTG-1];
endmodule

// ===== sv/rotated_ellipse_orbit_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_ellipse_orbit_point
// Maps a time sample to a point on a tilted elliptical orbit, Q15.16.
// ----------------------------------------------------------------------------
// req_ch carries elapsed_time; each request gives exactly one result on rsp_ch
// with pos_x, pos_y, pos_z and a fault code. csr_ch writes the six registers
// (axes, period, three tilts) and is always ready; the user must see that it is
// written while idle; the block does not enforce this. The datapath is a row
// of cells: two squaring stages, 31 square-root cells, 47 phase-division
// cells, one angle setup stage, 18 cordic cells and an 8-stage rotation
// pipeline. One request is accepted every cycle unless the row holds.
// The result side has a two-entry output buffer: requests keep flowing while
// one result waits. Once both entries are full the whole row holds and
// req_ch.ready drops until rsp_ch takes a result.
// Reset clears all valid state and loads the register reset values; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module rotated_ellipse_orbit_point (
   input  logic         clock,
   input  logic         reset,
   reop_req_if.sink     req_ch,
   reop_rsp_if.source   rsp_ch,
   reop_csr_if.sink     csr_ch
);
   localparam int LW = reop_pkg::LEN_W;
   localparam int AB = reop_pkg::ANGLE_BITS;
   localparam int NS = reop_pkg::SQRT_CELLS;
   localparam int ND = reop_pkg::DIV_CELLS;
   localparam int NC = reop_pkg::CORDIC_STAGES;

   logic [LW-1:0] semi_major_ff, semi_minor_ff, orbit_period_ff;
   logic [reop_pkg::TILT_W-1:0] tilt_x_ff, tilt_y_ff, tilt_z_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_major_ff   <= reop_pkg::LEN_RESET;
         semi_minor_ff   <= reop_pkg::LEN_RESET;
         orbit_period_ff <= reop_pkg::LEN_RESET;
         tilt_x_ff       <= '0;
         tilt_y_ff       <= '0;
         tilt_z_ff       <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            reop_pkg::REG_SEMI_MAJOR:   semi_major_ff   <= csr_ch.data;
            reop_pkg::REG_SEMI_MINOR:   semi_minor_ff   <= csr_ch.data;
            reop_pkg::REG_ORBIT_PERIOD: orbit_period_ff <= csr_ch.data;
            reop_pkg::REG_TILT_X:       tilt_x_ff <= csr_ch.data[reop_pkg::TILT_W-1:0];
            reop_pkg::REG_TILT_Y:       tilt_y_ff <= csr_ch.data[reop_pkg::TILT_W-1:0];
            reop_pkg::REG_TILT_Z:       tilt_z_ff <= csr_ch.data[reop_pkg::TILT_W-1:0];
            default: ;
         endcase
      end
   end

   // output buffer and flow control
   logic [1:0]           cnt_ff, cnt_in;
   reop_pkg::result_type buf0_ff, buf1_ff;
   logic                 en, push, pop;
   logic                 rot_valid;
   reop_pkg::result_type rot_result;

   assign en   = (cnt_ff != 2'd2);
   assign push = rot_valid && en;
   assign pop  = (cnt_ff != 2'd0) && rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               buf0_ff <= rot_result;
            end
         end
         2'd1: begin
            if (push && pop) begin
               buf0_ff <= rot_result;
            end else if (push) begin
               buf1_ff <= rot_result;
            end
         end
         default: begin
            if (pop) begin
               buf0_ff <= buf1_ff;
            end
         end
      endcase
   end

   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign rsp_ch.pos_x = buf0_ff.pos_x;
   assign rsp_ch.pos_y = buf0_ff.pos_y;
   assign rsp_ch.pos_z = buf0_ff.pos_z;
   assign rsp_ch.fault = buf0_ff.fault;

   // entry and squaring stages
   reop_pkg::item_type item_new;
   logic               s0_valid_ff, s1_valid_ff;
   reop_pkg::item_type s0_item_ff, s1_item_ff, s1_item_in;
   logic [reop_pkg::SQ_W-1:0] aa_ff, bb_ff;

   always_comb begin
      item_new       = '0;
      item_new.a     = semi_major_ff;
      item_new.b     = semi_minor_ff;
      item_new.p     = orbit_period_ff;
      item_new.num   = req_ch.elapsed_time;
      item_new.tx    = tilt_x_ff;
      item_new.ty    = tilt_y_ff;
      item_new.tz    = tilt_z_ff;
      if (orbit_period_ff == '0) begin
         item_new.fault = reop_pkg::FAULT_PERIOD;
      end else if (semi_minor_ff > semi_major_ff) begin
         item_new.fault = reop_pkg::FAULT_MINOR_AXIS;
      end else begin
         item_new.fault = reop_pkg::FAULT_NONE;
      end
   end

   always_comb begin
      s1_item_in     = s0_item_ff;
      s1_item_in.rad = aa_ff - bb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_ch.valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_item_ff <= item_new;
         aa_ff      <= semi_major_ff * semi_major_ff;
         bb_ff      <= semi_minor_ff * semi_minor_ff;
         s1_item_ff <= s1_item_in;
      end
   end

   // square root row
   logic               sq_valid [NS+1];
   reop_pkg::item_type sq_item  [NS+1];
   assign sq_valid[0] = s1_valid_ff;
   assign sq_item[0]  = s1_item_ff;

   for (genvar g = 0; g < NS; g++) begin : g_sqrt
      reop_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[g]),
         .in_item   (sq_item[g]),
         .out_valid (sq_valid[g+1]),
         .out_item  (sq_item[g+1])
      );
   end

   // phase division row
   logic               dv_valid [ND+1];
   reop_pkg::item_type dv_item  [ND+1];
   assign dv_valid[0] = sq_valid[NS];
   assign dv_item[0]  = sq_item[NS];

   for (genvar g = 0; g < ND; g++) begin : g_div
      reop_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[g]),
         .in_item   (dv_item[g]),
         .out_valid (dv_valid[g+1]),
         .out_item  (dv_item[g+1])
      );
   end

   // angle setup: quadrant fold and cordic start values
   logic               an_valid_ff;
   reop_pkg::item_type an_item_ff, an_item_in;
   logic [31:0]        th  [reop_pkg::N_ANG];
   logic [31:0]        th_off [reop_pkg::N_ANG];
   logic [31:0]        dv  [reop_pkg::N_ANG];

   always_comb begin
      an_item_in = dv_item[ND];
      th[reop_pkg::ANG_PHASE] = {dv_item[ND].dq, (32-AB)'(0)};
      th[reop_pkg::ANG_TX]    = {dv_item[ND].tx, 16'h0000};
      th[reop_pkg::ANG_TY]    = {dv_item[ND].ty, 16'h0000};
      th[reop_pkg::ANG_TZ]    = {dv_item[ND].tz, 16'h0000};
      for (int k = 0; k < reop_pkg::N_ANG; k++) begin
         th_off[k] = th[k] + 32'h2000_0000;
         dv[k]     = th[k] - {th_off[k][31:30], 30'd0};
         an_item_in.quad[k] = th_off[k][31:30];
         an_item_in.cx[k]   = reop_pkg::CORDIC_K;
         an_item_in.cy[k]   = '0;
         an_item_in.cz[k]   = {{(reop_pkg::CS_W-32){dv[k][31]}}, dv[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         an_valid_ff <= 1'b0;
      end else if (en) begin
         an_valid_ff <= dv_valid[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an_item_ff <= an_item_in;
      end
   end

   // cordic row
   logic               cr_valid [NC+1];
   reop_pkg::item_type cr_item  [NC+1];
   assign cr_valid[0] = an_valid_ff;
   assign cr_item[0]  = an_item_ff;

   for (genvar g = 0; g < NC; g++) begin : g_cordic
      reop_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_idx (reop_pkg::CIDX_W'(g)),
         .in_valid  (cr_valid[g]),
         .in_item   (cr_item[g]),
         .out_valid (cr_valid[g+1]),
         .out_item  (cr_item[g+1])
      );
   end

   reop_rot u_rot (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (cr_valid[NC]),
      .in_item    (cr_item[NC]),
      .out_valid  (rot_valid),
      .out_result (rot_result)
   );
endmodule

// ===== sv/reop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reop_checker
// Port-level checks of the orbit point block, bound to the top level.
// ----------------------------------------------------------------------------
module reop_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [31:0]           pos_x,
   input logic signed [31:0]           pos_y,
   input logic signed [31:0]           pos_z,
   input logic [reop_pkg::FAULT_W-1:0] fault
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(fault))
      else $error("result dropped or changed while stalled");

   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (fault == reop_pkg::FAULT_NONE || fault == reop_pkg::FAULT_PERIOD ||
                     fault == reop_pkg::FAULT_MINOR_AXIS))
      else $error("undefined fault code");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fault != reop_pkg::FAULT_NONE |-> pos_x == 0 && pos_y == 0 && pos_z == 0)
      else $error("faulted result carries a nonzero point");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind rotated_ellipse_orbit_point reop_checker u_reop_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .pos_x     (rsp_ch.pos_x),
   .pos_y     (rsp_ch.pos_y),
   .pos_z     (rsp_ch.pos_z),
   .fault     (rsp_ch.fault)
);
